// ----- design/tlc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlc_pkg
// Shared types and constants of the two-level LRU template cache.
// ----------------------------------------------------------------------------
package tlc_pkg;

  localparam int PEERS_DEF     = 4;
  localparam int SOURCES_DEF   = 8;
  localparam int TEMPLATES_DEF = 16;

  localparam int IDX_W  = 8;   // index and age width of the scan unit (covers 256 entries)
  localparam int KEY_W  = 32;
  localparam int TKEY_W = 16;
  localparam int CFG_W  = 5;

  localparam logic [3:0] SRC_LIMIT_RST  = 4'd8;
  localparam logic [4:0] TMPL_LIMIT_RST = 5'd16;

  localparam logic [0:0] REG_SOURCE_LIMIT   = 1'd0;
  localparam logic [0:0] REG_TEMPLATE_LIMIT = 1'd1;

  typedef enum logic [1:0] {
    OP_FIND   = 2'd0,
    OP_TOUCH  = 2'd1,
    OP_INSERT = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef logic [IDX_W:0] cnt_t;

  // One entry presented to the scan unit.
  typedef struct packed {
    logic              start;
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [IDX_W-1:0]  age;
    logic [KEY_W-1:0]  mkey;
  } probe_t;

  // Running results of a scan.
  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  fidx;
    logic [IDX_W-1:0]  fage;
    logic              lru_ok;
    logic [IDX_W-1:0]  lru_idx;
    logic [IDX_W-1:0]  lru_age;
    logic [KEY_W-1:0]  lru_key;
    logic              free_ok;
    logic [IDX_W-1:0]  free_idx;
    cnt_t              nvalid;
  } scan_t;

endpackage
`default_nettype wire

// ----- design/tlc_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlc_ram
// Generic single-write, single-read RAM with a registered read.
// ----------------------------------------------------------------------------
module tlc_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [W-1:0]             wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- design/tlc_scan.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlc_scan
// Shared compare unit: takes one entry per cycle while en is set and tracks the youngest key
// match, the least recent valid entry, the first free slot and the fill count.
// ----------------------------------------------------------------------------
module tlc_scan (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire tlc_pkg::probe_t pr,
  output tlc_pkg::scan_t       res
);

  tlc_pkg::scan_t res_next;

  always_comb begin
    res_next = res;
    if (pr.start) begin
      res_next = '0;
    end else if (pr.en) begin
      if (pr.valid) begin
        res_next.nvalid = res.nvalid + tlc_pkg::cnt_t'(1);
        if (pr.key == pr.mkey && (!res.found || pr.age < res.fage)) begin
          res_next.found = 1'b1;
          res_next.fidx  = pr.idx;
          res_next.fage  = pr.age;
        end
        // Ties go to the later slot.
        if (!res.lru_ok || pr.age >= res.lru_age) begin
          res_next.lru_ok  = 1'b1;
          res_next.lru_idx = pr.idx;
          res_next.lru_age = pr.age;
          res_next.lru_key = pr.key;
        end
      end else if (!res.free_ok) begin
        res_next.free_ok  = 1'b1;
        res_next.free_idx = pr.idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res <= '0;
    end else begin
      res <= res_next;
    end
  end

endmodule
`default_nettype wire

// ----- design/two_level_lru_template_cache_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// two_level_lru_template_cache_unit
// Per-peer two-level LRU table of sources and templates, walked by a small
// sequencer around one shared compare unit.
// ----------------------------------------------------------------------------
//  channel  direction  contents
//  s_axis   in         opcode, peer_slot, source_key, template_key
//  m_axis   out        hit, indices, eviction flags and evicted keys
//  cfg      in         source_limit (index 0), template_limit (index 1)
//
//  A find or touch scans the sources, then the templates of the matching
//  source; a touch then sweeps those templates to update their ages. An
//  insert also drops the templates of an evicted source before its template
//  scan and ends with the sweep. A clear drops every template entry of the peer.
//  The template RAM is walked one entry a cycle on its single read port.
//  After reset the template RAM is cleared in one pass, during which no
//  word is accepted.
//  A finished word waits in the output register; the next word is taken
//  once it has been loaded there.
module two_level_lru_template_cache_unit #(
  parameter int PEERS     = tlc_pkg::PEERS_DEF,
  parameter int SOURCES   = tlc_pkg::SOURCES_DEF,
  parameter int TEMPLATES = tlc_pkg::TEMPLATES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [0:0]                cfg_index,
  input  wire logic [tlc_pkg::CFG_W-1:0] cfg_data,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  // opcode[1:0], peer_slot[3:2], source_key[35:4], template_key[51:36]
  input  wire logic [55:0]               s_tdata,
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  // hit[0], source_index[3:1], template_index[7:4], source_evicted[8],
  // template_evicted[9], evicted_source_key[41:10], evicted_template_key[57:42]
  output logic [63:0]                    m_tdata
);

  localparam int PW    = (PEERS > 1) ? $clog2(PEERS) : 1;
  localparam int SW    = (SOURCES > 1) ? $clog2(SOURCES) : 1;
  localparam int TW    = (TEMPLATES > 1) ? $clog2(TEMPLATES) : 1;
  localparam int AW    = PW + SW + TW;
  localparam int DEPTH = 1 << AW;
  localparam int NSG   = 1 << (PW + SW);
  localparam int RW    = 1 + TW + tlc_pkg::TKEY_W;
  localparam int CW    = AW + 1;

  typedef enum logic [7:0] {
    ST_CLR    = 8'b00000001,
    ST_IDLE   = 8'b00000010,
    ST_SSCAN  = 8'b00000100,
    ST_SDEC   = 8'b00001000,
    ST_SDROP  = 8'b00010000,
    ST_TSCAN  = 8'b00100000,
    ST_TDEC   = 8'b01000000,
    ST_TSWEEP = 8'b10000000
  } state_t;

  state_t state;
  logic   done_pend;   // result complete, waiting for the output register
  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_m1;

  tlc_pkg::op_t            op_r;
  logic [PW-1:0]           p_r;
  logic [tlc_pkg::KEY_W-1:0]  skey_r;
  logic [tlc_pkg::TKEY_W-1:0] tkey_r;
  logic [3:0]              src_limit;
  logic [4:0]              tmpl_limit;
  logic [SW-1:0]           s_sel;
  logic [SW-1:0]           s_drop;
  logic                    drop_all;
  logic [TW-1:0]           t_sel;
  logic [TW-1:0]           t_a;
  logic [TW-1:0]           t_lru;

  logic                    hit;
  logic [2:0]              sidx;
  logic [3:0]              tidx;
  logic                    sev;
  logic                    tev;
  logic [tlc_pkg::KEY_W-1:0]  sev_key;
  logic [tlc_pkg::TKEY_W-1:0] tev_key;

  logic                      src_valid [NSG];
  logic [SW-1:0]             src_age   [NSG];
  logic [tlc_pkg::KEY_W-1:0] src_id    [NSG];

  tlc_pkg::probe_t pr;
  tlc_pkg::scan_t  r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [RW-1:0] rdata;
  logic          rd_valid;
  logic [TW-1:0] rd_age;
  logic [tlc_pkg::TKEY_W-1:0] rd_key;
  logic [RW-1:0] sweep_word;
  logic [TW-1:0] jt;

  logic [PW-1:0]   in_p;
  tlc_pkg::op_t    in_op;
  logic            peer_ok;
  tlc_pkg::cnt_t   slim;
  tlc_pkg::cnt_t   tlim;
  logic            s_evict;
  logic [SW-1:0]   s_slot;
  logic            t_evict;
  logic [TW-1:0]   t_slot;
  logic [PW+SW-1:0] sg_scan;
  logic [PW+SW-1:0] sg_sel;
  logic [SW-1:0]   prom_age;
  logic            accept;

  assign accept  = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE) && !done_pend;
  assign in_p    = PW'(s_tdata[3:2]);
  assign in_op   = tlc_pkg::op_t'(s_tdata[1:0]);
  assign peer_ok = int'(s_tdata[3:2]) < PEERS;
  assign cnt_m1  = cnt - CW'(1);
  assign jt      = cnt_m1[TW-1:0];
  assign sg_scan = {p_r, cnt[SW-1:0]};
  assign sg_sel  = {p_r, s_sel};
  assign prom_age = src_age[sg_sel];

  assign rd_valid = rdata[RW-1];
  assign rd_age   = rdata[tlc_pkg::TKEY_W +: TW];
  assign rd_key   = rdata[tlc_pkg::TKEY_W-1:0];

  // Limits clamped into 1..capacity.
  always_comb begin
    if (src_limit == 4'd0) begin
      slim = tlc_pkg::cnt_t'(1);
    end else if (tlc_pkg::cnt_t'(src_limit) > tlc_pkg::cnt_t'(SOURCES)) begin
      slim = tlc_pkg::cnt_t'(SOURCES);
    end else begin
      slim = tlc_pkg::cnt_t'(src_limit);
    end
    if (tmpl_limit == 5'd0) begin
      tlim = tlc_pkg::cnt_t'(1);
    end else if (tlc_pkg::cnt_t'(tmpl_limit) > tlc_pkg::cnt_t'(TEMPLATES)) begin
      tlim = tlc_pkg::cnt_t'(TEMPLATES);
    end else begin
      tlim = tlc_pkg::cnt_t'(tmpl_limit);
    end
  end

  // Eviction and slot choice; the freed slot counts as free when it comes first.
  always_comb begin
    s_evict = ((r.nvalid + tlc_pkg::cnt_t'(1)) > slim) && r.lru_ok;
    if (s_evict) begin
      s_slot = (r.free_ok && r.free_idx < r.lru_idx) ? r.free_idx[SW-1:0] : r.lru_idx[SW-1:0];
    end else begin
      s_slot = r.free_ok ? r.free_idx[SW-1:0] : SW'(SOURCES - 1);
    end
    t_evict = ((r.nvalid + tlc_pkg::cnt_t'(1)) > tlim) && r.lru_ok;
    if (t_evict) begin
      t_slot = (r.free_ok && r.free_idx < r.lru_idx) ? r.free_idx[TW-1:0] : r.lru_idx[TW-1:0];
    end else begin
      t_slot = r.free_ok ? r.free_idx[TW-1:0] : TW'(TEMPLATES - 1);
    end
  end

  always_comb begin
    pr       = '0;
    pr.start = (state == ST_IDLE) || (state == ST_SDEC) || (state == ST_SDROP);
    if (state == ST_SSCAN) begin
      pr.en    = 1'b1;
      pr.idx   = tlc_pkg::IDX_W'(cnt[SW-1:0]);
      pr.valid = src_valid[sg_scan];
      pr.key   = src_id[sg_scan];
      pr.age   = tlc_pkg::IDX_W'(src_age[sg_scan]);
      pr.mkey  = skey_r;
    end else if (state == ST_TSCAN && cnt != '0) begin
      pr.en    = 1'b1;
      pr.idx   = tlc_pkg::IDX_W'(jt);
      pr.valid = rd_valid;
      pr.key   = tlc_pkg::KEY_W'(rd_key);
      pr.age   = tlc_pkg::IDX_W'(rd_age);
      pr.mkey  = tlc_pkg::KEY_W'(tkey_r);
    end
  end

  tlc_scan u_scan (
    .clk (clk),
    .rst (rst),
    .pr  (pr),
    .res (r)
  );

  // Read-modify-write of one template entry during the age sweep.
  always_comb begin
    sweep_word = rdata;
    if (op_r == tlc_pkg::OP_TOUCH) begin
      if (jt == t_sel) begin
        sweep_word = {1'b1, TW'(0), rd_key};
      end else if (rd_valid && rd_age < t_a) begin
        sweep_word = {1'b1, rd_age + 1'b1, rd_key};
      end
    end else begin
      if (jt == t_sel) begin
        sweep_word = {1'b1, TW'(0), tkey_r};
      end else if (tev && jt == t_lru) begin
        sweep_word = {1'b0, TW'(0), rd_key};
      end else if (rd_valid) begin
        sweep_word = {1'b1, rd_age + 1'b1, rd_key};
      end
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = {p_r, s_sel, cnt[TW-1:0]};
    case (state)
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt[AW-1:0];
      end
      ST_SDROP: begin
        ram_we    = 1'b1;
        ram_waddr = drop_all ? {p_r, cnt[SW+TW-1:0]} : {p_r, s_drop, cnt[TW-1:0]};
      end
      ST_TSWEEP: begin
        if (cnt != '0) begin
          ram_we    = 1'b1;
          ram_waddr = {p_r, s_sel, jt};
          ram_wdata = sweep_word;
        end
      end
      default: ;
    endcase
  end

  tlc_ram #(
    .W     (RW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (state == ST_SDEC && op_r == tlc_pkg::OP_INSERT && !r.found) begin
      src_id[{p_r, s_slot}] <= skey_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLR;
      done_pend  <= 1'b0;
      cnt        <= '0;
      m_tvalid   <= 1'b0;
      src_limit  <= tlc_pkg::SRC_LIMIT_RST;
      tmpl_limit <= tlc_pkg::TMPL_LIMIT_RST;
      for (int g = 0; g < NSG; g++) begin
        src_valid[g] <= 1'b0;
        src_age[g]   <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tlc_pkg::REG_SOURCE_LIMIT:   src_limit  <= cfg_data[3:0];
          tlc_pkg::REG_TEMPLATE_LIMIT: tmpl_limit <= cfg_data;
          default: ;
        endcase
      end

      if (done_pend && (!m_tvalid || m_tready)) begin
        m_tvalid  <= 1'b1;
        m_tdata   <= {6'd0, tev_key, sev_key, tev, sev, tidx, sidx, hit};
        done_pend <= 1'b0;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_CLR: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(DEPTH - 1)) begin
            cnt   <= '0;
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            op_r    <= in_op;
            p_r     <= in_p;
            skey_r  <= s_tdata[35:4];
            tkey_r  <= s_tdata[51:36];
            hit     <= 1'b0;
            sidx    <= '0;
            tidx    <= '0;
            sev     <= 1'b0;
            tev     <= 1'b0;
            sev_key <= '0;
            tev_key <= '0;
            cnt     <= '0;
            if (!peer_ok) begin
              done_pend <= 1'b1;
            end else if (in_op == tlc_pkg::OP_CLEAR) begin
              drop_all <= 1'b1;
              state    <= ST_SDROP;
              for (int j = 0; j < SOURCES; j++) begin
                src_valid[{in_p, SW'(j)}] <= 1'b0;
                src_age[{in_p, SW'(j)}]   <= '0;
              end
            end else begin
              drop_all <= 1'b0;
              state    <= ST_SSCAN;
            end
          end
        end
        ST_SSCAN: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(SOURCES - 1)) begin
            cnt   <= '0;
            state <= ST_SDEC;
          end
        end
        ST_SDEC: begin
          if (r.found) begin
            s_sel <= r.fidx[SW-1:0];
            state <= ST_TSCAN;
          end else if (op_r != tlc_pkg::OP_INSERT) begin
            done_pend <= 1'b1;
            state     <= ST_IDLE;
          end else begin
            // New source: age the others, drop the least recent if over limit.
            for (int j = 0; j < SOURCES; j++) begin
              if (SW'(j) == s_slot) begin
                src_valid[{p_r, SW'(j)}] <= 1'b1;
                src_age[{p_r, SW'(j)}]   <= '0;
              end else if (s_evict && SW'(j) == r.lru_idx[SW-1:0]) begin
                src_valid[{p_r, SW'(j)}] <= 1'b0;
                src_age[{p_r, SW'(j)}]   <= '0;
              end else if (src_valid[{p_r, SW'(j)}]) begin
                src_age[{p_r, SW'(j)}] <= src_age[{p_r, SW'(j)}] + 1'b1;
              end
            end
            if (s_evict) begin
              sev     <= 1'b1;
              sev_key <= r.lru_key;
              s_drop  <= r.lru_idx[SW-1:0];
              state   <= ST_SDROP;
            end else begin
              state <= ST_TSCAN;
            end
            s_sel <= s_slot;
          end
        end
        ST_SDROP: begin
          cnt <= cnt + CW'(1);
          if ((drop_all && cnt == CW'((1 << (SW + TW)) - 1)) ||
              (!drop_all && cnt == CW'((1 << TW) - 1))) begin
            cnt <= '0;
            if (drop_all) begin
              done_pend <= 1'b1;
              state     <= ST_IDLE;
            end else begin
              state <= ST_TSCAN;
            end
          end
        end
        ST_TSCAN: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(TEMPLATES)) begin
            cnt   <= '0;
            state <= ST_TDEC;
          end
        end
        ST_TDEC: begin
          if (op_r != tlc_pkg::OP_INSERT && !r.found) begin
            done_pend <= 1'b1;
            state     <= ST_IDLE;
          end else if (op_r == tlc_pkg::OP_FIND) begin
            hit       <= 1'b1;
            sidx      <= 3'(s_sel);
            tidx      <= 4'(r.fidx[TW-1:0]);
            done_pend <= 1'b1;
            state     <= ST_IDLE;
          end else begin
            hit  <= 1'b1;
            sidx <= 3'(s_sel);
            for (int j = 0; j < SOURCES; j++) begin
              if (src_valid[{p_r, SW'(j)}] && src_age[{p_r, SW'(j)}] < prom_age) begin
                src_age[{p_r, SW'(j)}] <= src_age[{p_r, SW'(j)}] + 1'b1;
              end
            end
            src_age[sg_sel] <= '0;
            if (op_r == tlc_pkg::OP_TOUCH) begin
              tidx  <= 4'(r.fidx[TW-1:0]);
              t_sel <= r.fidx[TW-1:0];
              t_a   <= r.fage[TW-1:0];
            end else begin
              tidx  <= 4'(t_slot);
              t_sel <= t_slot;
              tev   <= t_evict;
              t_lru <= r.lru_idx[TW-1:0];
              if (t_evict) begin
                tev_key <= r.lru_key[tlc_pkg::TKEY_W-1:0];
              end
            end
            state <= ST_TSWEEP;
          end
        end
        ST_TSWEEP: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(TEMPLATES)) begin
            cnt       <= '0;
            done_pend <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // A word taken in is not followed by another in the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("second word accepted while one is in progress");

  // A miss never reports an eviction.
  a_miss_no_evict: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[9:8] == 2'b00))
    else $error("eviction reported without a hit");

  // Template eviction comes only from an insert.
  a_tev_insert: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TDEC && op_r != tlc_pkg::OP_INSERT) |=> !tev)
    else $error("template eviction outside an insert");

  // The template RAM is left alone while waiting for a word.
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !ram_we)
    else $error("template RAM written while idle");

endmodule
`default_nettype wire
